// File: rtl/adp_pkg.sv
// Shared types and constants for the advertising data field parser.
`timescale 1ns / 1ps

package adp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned M_TDATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_NAME_CODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_CODE = 1'b1;

    localparam logic [BYTE_W-1:0] NAME_CODE_RST   = 8'd9;
    localparam logic [BYTE_W-1:0] VENDOR_CODE_RST = 8'd255;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        KIND_LEN     = 3'd0,
        KIND_TYPE    = 3'd1,
        KIND_NAME    = 3'd2,
        KIND_VENDOR  = 3'd3,
        KIND_OTHER   = 3'd4,
        KIND_IGNORED = 3'd5
    } t_kind;

    typedef struct packed {
        t_phase            phase;
        logic [BYTE_W-1:0] bytes_left;
        logic [BYTE_W-1:0] cur_type;
        logic [BYTE_W-1:0] offset_cnt;
    } t_parse_state;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] offset;
        logic              done;
        logic              trunc;
        logic              last;
    } t_result;

    localparam t_parse_state PARSE_RST = '{
        phase:      PH_LEN,
        bytes_left: '0,
        cur_type:   '0,
        offset_cnt: '0
    };

endpackage

// File: rtl/adv_data_field_parser_core.sv
// Top level of the advertising data field parser core.
`timescale 1ns / 1ps
// Each result is registered and shows on the master side in the cycle after its input transfer.
// Throughput: one byte per cycle while the master side accepts results; the parse state
// updates in the accepting cycle and the result register frees itself on the same edge it is taken.
// Reset (synchronous, i_rst_n low): parser returns to expecting a length byte,
// name code reloads to 9, vendor code to 255, output register is emptied.

module adv_data_field_parser_core
    import adp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // slave side: payload bytes
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] payload_byte
    input  logic                 s_tlast,   // payload_end
    // master side: one result per byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] byte_value, [15:8] field_kind_code,
                                            // [23:16] data_offset, [24] field_done,
                                            // [25] truncated, [31:26] zero
    output logic [2:0]           m_tuser,   // [2:0] byte_kind
    output logic                 m_tlast    // last
);

    logic [BYTE_W-1:0] r_name_code;
    logic [BYTE_W-1:0] r_vendor_code;
    t_parse_state      r_state;
    t_parse_state      n_state;
    t_result           r_out;
    t_result           n_out;
    logic              r_out_valid;
    logic              s_xfer;

    // result register empties on the same edge its transfer completes
    assign s_tready = !r_out_valid || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    adp_step u_step (
        .i_state       (r_state),
        .i_byte        (s_tdata),
        .i_end         (s_tlast),
        .i_name_code   (r_name_code),
        .i_vendor_code (r_vendor_code),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    // configuration registers; only written while the block is idle, which the block itself does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_code   <= NAME_CODE_RST;
            r_vendor_code <= VENDOR_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NAME_CODE:   r_name_code   <= i_cfg_data;
                CFG_VENDOR_CODE: r_vendor_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parse state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= PARSE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_out <= n_out;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'd0, r_out.trunc, r_out.done, r_out.offset, r_out.code, r_out.value};
    assign m_tuser  = r_out.kind;
    assign m_tlast  = r_out.last;

endmodule

// File: rtl/adp_step.sv
// Per-byte classification and next-state logic of the AD structure walker.
`timescale 1ns / 1ps

module adp_step
    import adp_pkg::*;
(
    input  t_parse_state      i_state,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_end,
    input  logic [BYTE_W-1:0] i_name_code,
    input  logic [BYTE_W-1:0] i_vendor_code,
    output t_parse_state      o_state,
    output t_result           o_result
);

    logic [BYTE_W-1:0] left_dec;
    t_parse_state      upd;
    t_result           res;

    assign left_dec = i_state.bytes_left - 8'd1;

    always_comb begin
        upd        = i_state;
        res.kind   = KIND_IGNORED;
        res.value  = i_byte;
        res.code   = '0;
        res.offset = '0;
        res.done   = 1'b0;
        res.trunc  = 1'b0;
        res.last   = i_end;

        case (i_state.phase)
            PH_LEN: begin
                res.kind = KIND_LEN;
                if (i_byte == '0) begin
                    upd.phase = PH_STOP;
                end else begin
                    upd.bytes_left = i_byte;
                    upd.phase      = PH_TYPE;
                end
            end
            PH_TYPE: begin
                res.kind       = KIND_TYPE;
                res.code       = i_byte;
                upd.cur_type   = i_byte;
                upd.offset_cnt = '0;
                upd.bytes_left = left_dec;
                if (left_dec == '0) begin
                    res.done  = 1'b1;
                    upd.phase = PH_LEN;
                end else begin
                    upd.phase = PH_DATA;
                end
            end
            PH_DATA: begin
                // name match wins when both codes are equal
                if (i_state.cur_type == i_name_code) begin
                    res.kind = KIND_NAME;
                end else if (i_state.cur_type == i_vendor_code) begin
                    res.kind = KIND_VENDOR;
                end else begin
                    res.kind = KIND_OTHER;
                end
                res.code       = i_state.cur_type;
                res.offset     = i_state.offset_cnt;
                upd.offset_cnt = i_state.offset_cnt + 8'd1;
                upd.bytes_left = left_dec;
                if (left_dec == '0) begin
                    res.done  = 1'b1;
                    upd.phase = PH_LEN;
                end
            end
            default: begin
                res.kind = KIND_IGNORED;
            end
        endcase

        // end of payload: flag an unfinished structure, then start over
        if (i_end) begin
            res.trunc = (upd.phase == PH_TYPE) || (upd.phase == PH_DATA);
            upd       = PARSE_RST;
        end
    end

    assign o_state  = upd;
    assign o_result = res;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the advertising data field parser core.
`timescale 1ns / 1ps

module tb_top;
    import adp_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;   // cycles with no transfer before giving up

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_NAME_CODE;
    logic [BYTE_W-1:0]    i_cfg_data = '0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata    = '0;     // [7:0] payload_byte
    logic                 s_tlast    = 1'b0;   // payload_end
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;             // [7:0] value, [15:8] code, [23:16] offset,
                                               // [24] done, [25] truncated
    logic [2:0]           m_tuser;             // [2:0] byte_kind
    logic                 m_tlast;

    adv_data_field_parser_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // idle odds in percent for the byte source and the result sink
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;

    int unsigned err_count   = 0;
    int unsigned bytes_sent  = 0;
    int unsigned quiet_count = 0;

    // parser shadow: register copies and parse state
    logic [BYTE_W-1:0] name_code   = NAME_CODE_RST;
    logic [BYTE_W-1:0] vendor_code = VENDOR_CODE_RST;
    t_phase            ps_phase    = PH_LEN;
    logic [BYTE_W-1:0] ps_left     = '0;
    logic [BYTE_W-1:0] ps_type     = '0;
    logic [BYTE_W-1:0] ps_off      = '0;

    t_result tagged_bytes_q[$];   // expected tags, oldest first

    // Tag one payload byte and advance the shadow parse state.
    function automatic t_result parse_byte(input logic [BYTE_W-1:0] b, input logic pend);
        t_result r;
        r.kind   = KIND_IGNORED;
        r.value  = b;
        r.code   = '0;
        r.offset = '0;
        r.done   = 1'b0;
        r.trunc  = 1'b0;
        r.last   = pend;
        case (ps_phase)
            PH_LEN: begin
                r.kind = KIND_LEN;
                if (b == '0) begin
                    ps_phase = PH_STOP;
                end else begin
                    ps_left  = b;
                    ps_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                r.kind  = KIND_TYPE;
                ps_type = b;
                r.code  = b;
                ps_off  = '0;
                ps_left = ps_left - 8'd1;
                if (ps_left == '0) begin
                    r.done   = 1'b1;
                    ps_phase = PH_LEN;
                end else begin
                    ps_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                // name match wins when both codes are equal
                if (ps_type == name_code)
                    r.kind = KIND_NAME;
                else if (ps_type == vendor_code)
                    r.kind = KIND_VENDOR;
                else
                    r.kind = KIND_OTHER;
                r.code   = ps_type;
                r.offset = ps_off;
                ps_off   = ps_off + 8'd1;
                ps_left  = ps_left - 8'd1;
                if (ps_left == '0) begin
                    r.done   = 1'b1;
                    ps_phase = PH_LEN;
                end
            end
            default: r.kind = KIND_IGNORED;
        endcase
        if (pend) begin
            if (ps_phase == PH_TYPE || ps_phase == PH_DATA)
                r.trunc = 1'b1;
            ps_phase = PH_LEN;
            ps_left  = '0;
            ps_type  = '0;
            ps_off   = '0;
        end
        return r;
    endfunction

    // Drive one byte; returns on the edge where the transfer happens.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic pend);
        logic taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= pend;
        do begin
            @(negedge i_clk);
            taken = s_tready;
            @(posedge i_clk);
        end while (!taken);
        tagged_bytes_q.push_back(parse_byte(b, pend));
        bytes_sent++;
    endtask

    // Stop sending and wait until every tagged byte has come back.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (tagged_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write both type code registers back to back; block must be idle.
    task automatic set_codes(input logic [BYTE_W-1:0] nm, input logic [BYTE_W-1:0] vd);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NAME_CODE;
        i_cfg_data <= nm;
        @(posedge i_clk);
        name_code  = nm;
        i_cfg_idx  <= CFG_VENDOR_CODE;
        i_cfg_data <= vd;
        @(posedge i_clk);
        vendor_code = vd;
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_seq(input logic [BYTE_W-1:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
    endtask

    // Build one payload: mostly well-formed structures, some cut short, some noise.
    task automatic send_payload(input bit force_long);
        logic [BYTE_W-1:0] seq[$];
        int unsigned       nstruct;
        int unsigned       len;
        int unsigned       pick;
        if (!force_long && $urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom));
        end else begin
            nstruct = $urandom_range(1, 4);
            for (int s = 0; s < nstruct; s++) begin
                pick = $urandom_range(99);
                if (force_long && s == 0) len = $urandom_range(200, 255);
                else if (pick < 3)        len = $urandom_range(130, 255);
                else if (pick < 8)        len = 0;
                else                      len = $urandom_range(1, 12);
                seq.push_back(len[7:0]);
                if (len == 0) begin
                    // zero length: trailing bytes are ignored
                    repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom));
                    break;
                end
                pick = $urandom_range(99);
                if (pick < 40)      seq.push_back(name_code);
                else if (pick < 65) seq.push_back(vendor_code);
                else                seq.push_back(8'($urandom));
                repeat (len - 1) seq.push_back(8'($urandom));
            end
            if ($urandom_range(99) < 15 && seq.size() > 1)
                seq = seq[0:$urandom_range(0, seq.size() - 2)];
        end
        send_seq(seq);
    endtask

    // Reset codes: name, vendor, other, one-byte structure, zero length and
    // every way a payload can end.
    task automatic test_default_codes;
        send_seq('{8'd3, 8'd9, 8'h41, 8'h42, 8'd2, 8'hFF, 8'h00, 8'd1, 8'h01,
                   8'd0, 8'hAB, 8'hFF});
        send_seq('{8'd2, 8'h07, 8'h55});      // ends on completing data byte
        send_seq('{8'd5});                    // ends on a length byte
        send_seq('{8'd4, 8'h16});             // ends on a type byte with data owed
        send_seq('{8'd3, 8'h02, 8'h80});      // ends inside the data
        send_seq('{8'd1, 8'h0A});             // ends on a completing type byte
    endtask

    // Both codes equal: name tagging wins, at both extremes.
    task automatic test_equal_codes;
        set_codes(8'h00, 8'h00);
        send_seq('{8'd2, 8'h00, 8'h11});
        set_codes(8'hFF, 8'hFF);
        send_seq('{8'd2, 8'hFF, 8'hEE});
    endtask

    task automatic run_random_phase(input int unsigned n, input bit with_long);
        int unsigned target;
        target = bytes_sent + n;
        if (with_long)
            send_payload(1'b1);
        while (bytes_sent < target)
            send_payload(1'b0);
    endtask

    task automatic test_random_payloads;
        src_idle_pct = 26;
        snk_idle_pct = 53;
        set_codes(8'($urandom), 8'($urandom));
        run_random_phase(200, 1'b0);
        src_idle_pct = 53;
        snk_idle_pct = 26;
        set_codes(8'h00, 8'hFF);
        run_random_phase(200, 1'b0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_codes(8'hFF, 8'h00);
        run_random_phase(200, 1'b1);
    endtask

    always @(posedge i_clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    function automatic void check_field(input string fname, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            err_count++;
        end
    endfunction

    // Result checker and stall watchdog; mid-cycle sampling sees settled
    // signals, a transfer seen here completes at the next rising edge.
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_count = 0;
            else
                quiet_count++;
            if (m_tvalid && m_tready) begin
                if (tagged_bytes_q.size() == 0) begin
                    $error("result with no byte pending: tdata %h tuser %0d", m_tdata, m_tuser);
                    err_count++;
                end else begin
                    want = tagged_bytes_q.pop_front();
                    check_field("byte_kind",       want.kind,   m_tuser);
                    check_field("byte_value",      want.value,  m_tdata[7:0]);
                    check_field("field_kind_code", want.code,   m_tdata[15:8]);
                    check_field("data_offset",     want.offset, m_tdata[23:16]);
                    check_field("field_done",      want.done,   m_tdata[24]);
                    check_field("truncated",       want.trunc,  m_tdata[25]);
                    check_field("last",            want.last,   m_tlast);
                end
            end
            if (quiet_count >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        src_idle_pct = 26;
        snk_idle_pct = 53;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_codes();
        test_equal_codes();
        test_random_payloads();
        drain();
        if (tagged_bytes_q.size() != 0)
            err_count++;
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
